[src/gspm_pkg.sv]
// Package with the shared types, constants and the command byte table of the gamepad poll master.
`default_nettype none

package gspm_pkg;

  // Default number of response bytes clocked in after the poll command.
  localparam int unsigned RESPONSE_BYTES_DEF = 7;

  // Response bytes that feed the report: status, two button bytes, four stick bytes.
  localparam int unsigned REPORT_BYTES = 7;
  localparam int unsigned RepIdxW      = $clog2(REPORT_BYTES);

  // Command bytes of the link.
  localparam logic [7:0] CMD_START   = 8'h01;
  localparam logic [7:0] CMD_POLL    = 8'h42;
  localparam logic [7:0] CMD_CONFIG  = 8'h43;
  localparam logic [7:0] CMD_MOTOR   = 8'h4D;
  localparam logic [7:0] PAD_READY   = 8'h5A;

  // Input kinds carried in tuser.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_POLL    = 2'd1;
  localparam logic [1:0] KIND_VIBRATE = 2'd2;

  // Vibrate frame numbers.
  localparam logic [1:0] VF_ENTER  = 2'd0;
  localparam logic [1:0] VF_ENABLE = 2'd1;
  localparam logic [1:0] VF_EXIT   = 2'd2;
  localparam logic [1:0] VF_DRIVE  = 2'd3;

  // Frame lengths in bytes.
  localparam logic [3:0] POLL_CMD_LEN   = 4'd2;
  localparam logic [3:0] VIB_LEN_SHORT  = 4'd5;
  localparam logic [3:0] VIB_LEN_LONG   = 4'd9;

  typedef enum logic [2:0] {
    OP_IDLE = 3'b001,
    OP_POLL = 3'b010,
    OP_VIB  = 3'b100
  } op_e;

  typedef enum logic [3:0] {
    PH_GAP  = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_e;

  typedef struct packed {
    logic               en;
    logic [RepIdxW-1:0] idx;
    logic [7:0]         data;
  } resp_wr_t;

  typedef struct packed {
    logic        connected;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } report_t;

  // Byte to send at a given place of a frame. Poll frames past the command
  // and vibrate bytes past the end of the table send zero.
  function automatic logic [7:0] frame_byte(input logic       is_poll,
                                            input logic [1:0] frame,
                                            input logic [3:0] byte_idx,
                                            input logic [7:0] small_hold,
                                            input logic [7:0] large_hold);
    logic [7:0] b;
    b = 8'h00;
    if (is_poll) begin
      if (frame == VF_ENTER) begin
        b = (byte_idx == 4'd0) ? CMD_START : CMD_POLL;
      end
    end else if (byte_idx < 4'd9) begin
      if (byte_idx == 4'd0) begin
        b = CMD_START;
      end else begin
        unique case (frame)
          VF_ENTER: begin
            if (byte_idx == 4'd1) b = CMD_CONFIG;
            else if (byte_idx == 4'd3) b = 8'h01;
          end
          VF_ENABLE: begin
            if (byte_idx == 4'd1) b = CMD_MOTOR;
            else if (byte_idx == 4'd4) b = 8'h01;
          end
          VF_EXIT: begin
            if (byte_idx == 4'd1) b = CMD_CONFIG;
            else if (byte_idx >= 4'd4) b = PAD_READY;
          end
          default: begin
            if (byte_idx == 4'd1) b = CMD_POLL;
            else if (byte_idx == 4'd3) b = small_hold;
            else if (byte_idx == 4'd4) b = large_hold;
          end
        endcase
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[src/gspm_resp.sv]
// Response byte store of the gamepad poll master and the report built from it.
`default_nettype none

module gspm_resp (
  input  logic                clk_i,
  input  gspm_pkg::resp_wr_t  wr_i,
  input  logic                done_i,
  output gspm_pkg::report_t   report_o
);
  import gspm_pkg::*;

  logic [7:0] bytes_q [REPORT_BYTES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      bytes_q[wr_i.idx] <= wr_i.data;
    end
  end

  // Fields read as zero unless a poll completes this tick.
  always_comb begin
    report_o = '0;
    if (done_i) begin
      report_o.connected = (bytes_q[0] == PAD_READY);
      report_o.buttons   = {bytes_q[2], bytes_q[1]};
      report_o.right_x   = bytes_q[3];
      report_o.right_y   = bytes_q[4];
      report_o.left_x    = bytes_q[5];
      report_o.left_y    = bytes_q[6];
    end
  end

endmodule

`default_nettype wire

[src/gamepad_serial_poll_master.sv]
// Top level of the gamepad serial poll master: tick sequencer, config register and result register.
`default_nettype none

// Every input transaction is one tick of the bit-banged gamepad link and produces exactly one
// result transaction holding the pin levels for that tick (select, clock, command), the busy
// flag and, on the tick a poll ends, the decoded report. One tick is processed per clock: the
// sequencer state advances in the cycle the tick is accepted and the result lands in a single
// output register, so a new tick is accepted every cycle as long as the downstream side takes
// results (input ready is low only while an unread result is stalled). A bit takes two ticks,
// clock high then clock low; the data line is sampled on the clock-low tick of each received
// bit. A poll request sends 0x01 0x42 and clocks in RESPONSE_BYTES bytes, then raises select
// and flags poll_done. A vibrate request runs four command-only frames with gap_ticks idle
// ticks after each select edge. Requests that arrive while a sequence runs are ignored.
// gap_ticks is written through cfg_we_i/cfg_wdata_i and must only change while the block is idle.

module gamepad_serial_poll_master #(
  parameter int unsigned RESPONSE_BYTES = gspm_pkg::RESPONSE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: gap_ticks.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input ticks.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata from bit 0: data_in[0], small_motor[8:1], large_motor[16:9], zero fill[23:17].
  input  logic [23:0] s_axis_tdata_i,
  // tuser: kind[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  // Results.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata from bit 0: select_n[0], clock_level[1], command_bit[2], busy_res[3], connected[4],
  // buttons[20:5], right_x[28:21], right_y[36:29], left_x[44:37], left_y[52:45], zero[55:53].
  output logic [55:0] m_axis_tdata_o,
  // tuser: poll_done[0].
  output logic        m_axis_tuser_o
);
  import gspm_pkg::*;

  // The byte counter must hold the response length itself and the vibrate frame length.
  localparam int unsigned IdxW =
      ($clog2(RESPONSE_BYTES + 1) > 4) ? $clog2(RESPONSE_BYTES + 1) : 4;

  // Configuration register.
  logic [7:0] gap_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= 8'd16;
    end else if (cfg_we_i) begin
      gap_ticks_q <= cfg_wdata_i;
    end
  end

  // Sequencer state.
  op_e             op_q, op_d;
  phase_e          phase_q, phase_d;
  logic [1:0]      frame_q, frame_d;
  logic [IdxW-1:0] byte_q, byte_d;
  logic [2:0]      bit_q, bit_d;
  logic [7:0]      gap_q, gap_d;
  logic [7:0]      tx_q, tx_d;
  logic [7:0]      rx_q, rx_d;
  logic [7:0]      small_q, small_d;
  logic [7:0]      large_q, large_d;

  logic       accept;
  logic [1:0] kind;
  logic       din;
  logic       sel, clk_lvl, cmd, done;
  resp_wr_t   resp_wr;
  report_t    report;

  assign kind   = s_axis_tuser_i;
  assign din    = s_axis_tdata_i[0];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    logic            receiving;
    logic            is_poll;
    logic [7:0]      rx_new;
    logic [IdxW-1:0] byte_n;
    logic [IdxW-1:0] len;
    logic [2:0]      bit_n;

    op_d    = op_q;
    phase_d = phase_q;
    frame_d = frame_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    gap_d   = gap_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    small_d = small_q;
    large_d = large_q;
    sel     = 1'b1;
    clk_lvl = 1'b1;
    cmd     = 1'b0;
    done    = 1'b0;
    resp_wr = '0;

    is_poll   = (op_q == OP_POLL);
    receiving = is_poll && (frame_q == 2'd1);
    rx_new    = rx_q | (8'(receiving && din) << bit_q);
    bit_n     = bit_q + 3'd1;
    byte_n    = byte_q + IdxW'(1);
    if (is_poll) begin
      len = receiving ? IdxW'(RESPONSE_BYTES) : IdxW'(POLL_CMD_LEN);
    end else begin
      len = (frame_q == VF_ENABLE) ? IdxW'(VIB_LEN_SHORT) : IdxW'(VIB_LEN_LONG);
    end

    if (op_q == OP_IDLE) begin
      // A request tick is itself the select-fall tick.
      if (kind == KIND_POLL || kind == KIND_VIBRATE) begin
        frame_d = VF_ENTER;
        byte_d  = '0;
        bit_d   = '0;
        rx_d    = '0;
        sel     = 1'b0;
        if (kind == KIND_VIBRATE) begin
          op_d    = OP_VIB;
          small_d = s_axis_tdata_i[8:1];
          large_d = s_axis_tdata_i[16:9];
          tx_d    = CMD_START;
          phase_d = PH_GAP;
          gap_d   = gap_ticks_q;
        end else begin
          op_d    = OP_POLL;
          tx_d    = CMD_START;
          phase_d = PH_HIGH;
        end
      end
    end else begin
      unique case (phase_q)
        PH_GAP, PH_HIGH: begin
          if (phase_q == PH_GAP && gap_q != 8'd0) begin
            gap_d = gap_q - 8'd1;
            sel   = 1'b0;
          end else begin
            // An expired lead gap falls straight into the clock-high tick.
            sel     = 1'b0;
            cmd     = tx_q[bit_q];
            phase_d = PH_LOW;
          end
        end
        PH_LOW: begin
          sel     = 1'b0;
          clk_lvl = 1'b0;
          cmd     = tx_q[bit_q];
          bit_d   = bit_n;
          if (bit_n != 3'd0) begin
            rx_d    = rx_new;
            phase_d = PH_HIGH;
          end else begin
            // Byte boundary.
            if (receiving && byte_q < IdxW'(REPORT_BYTES)) begin
              resp_wr.en   = 1'b1;
              resp_wr.idx  = byte_q[RepIdxW-1:0];
              resp_wr.data = rx_new;
            end
            rx_d   = '0;
            byte_d = byte_n;
            if (byte_n >= len) begin
              if (is_poll && frame_q == 2'd0) begin
                frame_d = 2'd1;
                byte_d  = '0;
                tx_d    = '0;
                phase_d = PH_HIGH;
              end else begin
                phase_d = PH_TAIL;
                gap_d   = gap_ticks_q;
                bit_d   = '0;
              end
            end else begin
              tx_d    = frame_byte(is_poll, frame_q, byte_n[3:0], small_q, large_q);
              phase_d = PH_HIGH;
            end
          end
        end
        default: begin
          // Tail: the select-rise tick, then the trailing gap of a vibrate frame. bit_q marks
          // whether the rise tick has passed.
          if (is_poll) begin
            done = 1'b1;
            op_d = OP_IDLE;
          end else if (bit_q == 3'd0) begin
            bit_d = 3'd1;
          end else if (gap_q != 8'd0) begin
            gap_d = gap_q - 8'd1;
          end else if (frame_q != VF_DRIVE) begin
            frame_d = frame_q + 2'd1;
            byte_d  = '0;
            bit_d   = '0;
            rx_d    = '0;
            tx_d    = CMD_START;
            phase_d = PH_GAP;
            gap_d   = gap_ticks_q;
            sel     = 1'b0;
          end else begin
            op_d = OP_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      phase_q <= PH_GAP;
      frame_q <= '0;
      byte_q  <= '0;
      bit_q   <= '0;
      gap_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      small_q <= '0;
      large_q <= '0;
    end else if (accept) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      frame_q <= frame_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      gap_q   <= gap_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      small_q <= small_d;
      large_q <= large_d;
    end
  end

  resp_wr_t resp_wr_gated;

  always_comb begin
    resp_wr_gated    = resp_wr;
    resp_wr_gated.en = resp_wr.en && accept;
  end

  gspm_resp u_resp (
    .clk_i    (clk_i),
    .wr_i     (resp_wr_gated),
    .done_i   (done),
    .report_o (report)
  );

  // Result register. It refills in the same cycle it is drained.
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic        out_user_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {3'b000, report.left_y, report.left_x, report.right_y, report.right_x,
                     report.buttons, report.connected, (op_d != OP_IDLE), cmd, clk_lvl, sel};
      out_user_q <= done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef NO_ASSERTIONS
  // A completed poll leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !m_axis_tdata_o[3])
    else $error("poll_done reported while still busy");

  // The serial clock only goes low inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[1]) |-> !m_axis_tdata_o[0])
    else $error("clock low with select high");

  // Report fields stay zero on every result that is not a poll completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[55:4] == '0))
    else $error("report fields nonzero without poll_done");

  // With the result register empty a tick is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // The sequencer state only moves on an accepted tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(op_q) && $stable(phase_q))
    else $error("sequencer advanced without a tick");
`endif

endmodule

`default_nettype wire
